### design/nvs_pkg.sv
// ----------------------------------------------------------------------------
// nvs_pkg: shared types and constants for the nearest value search core
// Transaction payload structs, action codes and register reset value.
// ----------------------------------------------------------------------------
package nvs_pkg;

    // Field widths fixed by the transaction format
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COUNT_W = 5;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Reset value of the entries-in-use register
    localparam logic [COUNT_W-1:0] ENTRIES_IN_USE_RST = 5'd10;

    typedef struct packed {
        logic                    action;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] query_value;
    } nvs_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] nearest;
        logic [VAL_W-1:0]        distance;
    } nvs_result_t;

endpackage

### design/nearest_value_search_core.sv
// ----------------------------------------------------------------------------
// nearest_value_search_core: nearest stored value to a query
// A query's result strobes on done once the scan has read count table entries,
// count being entries_in_use clamped to 1..ENTRIES (one table read per cycle).
// A query holds busy until its result strobes; loads are taken every cycle while idle.
// Reset: control is cleared and entries_in_use is reset to 10; table undefined.
// ----------------------------------------------------------------------------
module nearest_value_search_core #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  nvs_pkg::nvs_item_t                  item,
    output logic                                done,
    output nvs_pkg::nvs_result_t                result,
    input  logic                                cfg_we,
    input  logic [nvs_pkg::COUNT_W-1:0]         cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [nvs_pkg::COUNT_W-1:0]      entries_reg;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [IDX_W-1:0]                 last_idx_reg, last_idx_next;
    logic signed [nvs_pkg::VAL_W-1:0] query_reg;
    logic                             rd_vld_reg, rd_last_reg, first_reg;
    logic signed [nvs_pkg::VAL_W-1:0] rd_data_reg;
    logic signed [nvs_pkg::VAL_W-1:0] mem [ENTRIES];
    logic                             done_reg;
    nvs_pkg::nvs_result_t             result_reg;
    nvs_pkg::nvs_result_t             best_next;
    logic                             accept, load_we, query_go, scanning;
    int unsigned                      cnt_ext;

    assign accept   = start && (state_reg == ST_IDLE);
    assign load_we  = accept && (item.action == nvs_pkg::ACT_LOAD)
                      && (32'(item.slot) < ENTRIES);
    assign query_go = accept && (item.action == nvs_pkg::ACT_QUERY);
    assign scanning = (state_reg == ST_SCAN);

    // Clamp the search count and turn it into the last index
    always_comb
    begin
        cnt_ext = 32'(entries_reg);
        priority if (cnt_ext == 0)
            last_idx_next = '0;
        else if (cnt_ext > ENTRIES)
            last_idx_next = IDX_W'(ENTRIES - 1);
        else
            last_idx_next = IDX_W'(cnt_ext - 1);
    end

    // Sequence the scan
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (query_go)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == last_idx_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (rd_vld_reg && rd_last_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            entries_reg <= nvs_pkg::ENTRIES_IN_USE_RST;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            first_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= scanning;
            rd_last_reg <= scanning && (idx_reg == last_idx_reg);
            done_reg    <= rd_vld_reg && rd_last_reg;
            if (query_go)
                first_reg <= 1'b1;
            else if (rd_vld_reg)
                first_reg <= 1'b0;
            if (cfg_we)
                entries_reg <= cfg_wdata;
        end
    end

    // Capture query payload and clamped count
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            query_reg    <= item.query_value;
            last_idx_reg <= last_idx_next;
        end
        if (rd_vld_reg && rd_last_reg)
            result_reg <= best_next;
    end

    // Table memory: write on load, registered read during scan
    always_ff @(posedge clk)
    begin
        if (load_we)
            mem[IDX_W'(item.slot)] <= item.entry_value;
        rd_data_reg <= mem[idx_reg];
    end

    nvs_best_unit u_best (
        .clk        (clk),
        .query      (query_reg),
        .data       (rd_data_reg),
        .data_valid (rd_vld_reg),
        .first      (first_reg),
        .best_next  (best_next)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/nvs_best_unit.sv
// ----------------------------------------------------------------------------
// nvs_best_unit: running best-candidate tracker
// Forms the exact absolute difference of one table word against the query
// and keeps the closest word seen so far, the smaller one on equal distance.
// ----------------------------------------------------------------------------
module nvs_best_unit (
    input  logic                                 clk,
    input  logic signed [nvs_pkg::VAL_W-1:0]     query,
    input  logic signed [nvs_pkg::VAL_W-1:0]     data,
    input  logic                                 data_valid,
    input  logic                                 first,
    output nvs_pkg::nvs_result_t                 best_next
);

    nvs_pkg::nvs_result_t            best_reg;
    logic signed [nvs_pkg::VAL_W:0]  diff;
    logic [nvs_pkg::VAL_W:0]         diff_abs;
    logic [nvs_pkg::VAL_W-1:0]       gap;
    logic                            take;

    // Form the 33-bit difference and its magnitude
    always_comb
    begin
        diff     = {query[nvs_pkg::VAL_W-1], query} - {data[nvs_pkg::VAL_W-1], data};
        diff_abs = diff[nvs_pkg::VAL_W] ? (~diff + 1'b1) : diff;
        gap      = diff_abs[nvs_pkg::VAL_W-1:0];
    end

    // Decide whether the new word replaces the current best
    always_comb
    begin
        take = first
            || (gap < best_reg.distance)
            || ((gap == best_reg.distance) && (data < best_reg.nearest));
        best_next = best_reg;
        if (data_valid && take)
        begin
            best_next.nearest  = data;
            best_next.distance = gap;
        end
    end

    // Hold the running best
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for nearest_value_search_core
// Loads the value table, then runs directed and random query traffic across
// several entries_in_use settings. A shadow table predicts the nearest entry
// and its distance for every accepted query. Each strobed result is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nvs_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int HALF_PERIOD = 5;
    // Settle past the longest query, which scans all ENTRIES entries
    localparam int SETTLE      = ENTRIES + 8;
    localparam int PHASE_ITEMS = 70;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    nvs_item_t            item_r    = '0;
    logic                 done;
    nvs_result_t          result;
    logic                 cfg_we    = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;

    // Transactions waiting to be driven and results still owed by the core
    nvs_item_t            pending_items[$];
    nvs_result_t          expected_results[$];

    // Shadow copy of the table and of the entries-in-use register
    logic signed [VAL_W-1:0] shadow_table [ENTRIES];
    logic [COUNT_W-1:0]      shadow_count = ENTRIES_IN_USE_RST;

    int error_count = 0;
    int gap_left    = 0;
    int calm_left   = 0;
    bit calm_mode   = 1'b0;

    nearest_value_search_core #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item_r),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Exact absolute difference, formed at 33 bits
    function automatic logic [VAL_W-1:0] abs_gap(logic signed [VAL_W-1:0] a,
                                                 logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] diff;
        diff = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
        if (diff < 0)
        begin
            diff = -diff;
        end
        return diff[VAL_W-1:0];
    endfunction

    // Search the shadow table for the entry nearest to q, smaller on ties
    function automatic nvs_result_t predict_nearest(logic signed [VAL_W-1:0] q);
        int                      n;
        logic signed [VAL_W-1:0] best;
        logic signed [VAL_W-1:0] v;
        logic [VAL_W-1:0]        best_d;
        logic [VAL_W-1:0]        d;
        nvs_result_t             r;
        n = int'(shadow_count);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > ENTRIES)
        begin
            n = ENTRIES;
        end
        best   = shadow_table[0];
        best_d = abs_gap(q, best);
        for (int i = 1; i < n; i++)
        begin
            v = shadow_table[i];
            d = abs_gap(q, v);
            if (d < best_d || (d == best_d && v < best))
            begin
                best   = v;
                best_d = d;
            end
        end
        r.nearest  = best;
        r.distance = best_d;
        return r;
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Driver: present queued transactions, with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            start    <= 1'b0;
            item_r   <= '0;
            gap_left = 0;
        end
        else
        begin
            // Record the accepted transaction in the shadow model
            if (start && !busy)
            begin
                if (item_r.action == ACT_QUERY)
                begin
                    expected_results.push_back(predict_nearest(item_r.query_value));
                end
                else
                begin
                    shadow_table[item_r.slot] = item_r.entry_value;
                end
                // Switch between back-to-back stretches and gappy stretches
                if (calm_left == 0)
                begin
                    calm_mode = ($urandom_range(0, 3) == 0);
                    calm_left = $urandom_range(20, 60);
                end
                calm_left--;
                case ($urandom_range(0, 99)) inside
                    [0:59]:  gap_left = 0;
                    [60:89]: gap_left = $urandom_range(1, 3);
                    [90:97]: gap_left = $urandom_range(4, 20);
                    default: gap_left = $urandom_range(30, 80);
                endcase
                if (calm_mode)
                begin
                    gap_left = 0;
                end
            end
            // Advance to the next transaction once the current one is taken
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item_r <= pending_items.pop_front();
                    start  <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every strobed result against the oldest prediction
    always @(posedge clk)
    begin : monitor
        nvs_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                note_error($sformatf("unexpected result nearest=%0d distance=%0d",
                                     result.nearest, result.distance));
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.nearest !== want.nearest)
                begin
                    note_error($sformatf("nearest expected %0d got %0d",
                                         want.nearest, result.nearest));
                end
                if (result.distance !== want.distance)
                begin
                    note_error($sformatf("distance expected %0d got %0d",
                                         want.distance, result.distance));
                end
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            1, 2, 3, 4: v = int'($urandom_range(0, 16)) - 8;
            default:    v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_item(logic act, logic [SLOT_W-1:0] slot,
                            logic signed [VAL_W-1:0] entry_value,
                            logic signed [VAL_W-1:0] query_value);
        nvs_item_t it;
        it.action      = act;
        it.slot        = slot;
        it.entry_value = entry_value;
        it.query_value = query_value;
        pending_items.push_back(it);
    endtask

    task automatic add_query(logic signed [VAL_W-1:0] q);
        add_item(ACT_QUERY, SLOT_W'($urandom), $urandom, q);
    endtask

    // Mostly queries, with loads mixed in to keep the table moving
    task automatic add_random_items(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_item(ACT_LOAD, SLOT_W'($urandom), rand_value(), $urandom);
            end
            else
            begin
                add_query(rand_value());
            end
        end
    endtask

    // Wait until all traffic has drained, then let the core settle
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || start || expected_results.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write entries_in_use while idle; returns on a falling edge
    task automatic write_count(logic [COUNT_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        shadow_count = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [COUNT_W-1:0] settings [10];
        settings = '{5'd31, 5'd16, 5'd17, 5'd1, 5'd0, 5'd2, 5'd5, 5'd9, 5'd15, 5'd24};
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_table[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every entry first, so no query reads an unwritten one
        add_item(ACT_LOAD, 4'd0, 32'sh8000_0000, $urandom);
        add_item(ACT_LOAD, 4'd1, 32'sh7FFF_FFFF, $urandom);
        add_item(ACT_LOAD, 4'd2, 0, $urandom);
        add_item(ACT_LOAD, 4'd3, -1, $urandom);
        add_item(ACT_LOAD, 4'd4, 1, $urandom);
        add_item(ACT_LOAD, 4'd5, 100, $urandom);
        add_item(ACT_LOAD, 4'd6, -100, $urandom);
        add_item(ACT_LOAD, 4'd7, 32'sh4000_0000, $urandom);
        add_item(ACT_LOAD, 4'd8, 32'shC000_0000, $urandom);
        add_item(ACT_LOAD, 4'd9, 7, $urandom);
        for (int s = 10; s < ENTRIES; s++)
        begin
            add_item(ACT_LOAD, SLOT_W'(s), $urandom, $urandom);
        end

        // Reset count of ten: queries on both sides of zero and at the extremes
        add_query(50);
        add_query(-50);
        add_query(32'sh7FFF_FFFF);
        add_query(32'sh8000_0000);
        add_query(32'sh6000_0000);

        // Single entry: widest possible distance, and a zero query
        write_count(5'd1);
        add_query(32'sh7FFF_FFFF);
        add_query(0);

        // Zero count behaves as one
        write_count(5'd0);
        add_query(-5);

        // Random traffic over a spread of settings
        foreach (settings[k])
        begin
            write_count(settings[k]);
            add_random_items(PHASE_ITEMS);
        end

        wait_idle();
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Guard against a hung core
    initial
    begin : watchdog
        #(5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
design/nvs_pkg.sv
design/nvs_best_unit.sv
design/nearest_value_search_core.sv
tb/tb_top.sv
